[hdl/lsce_pkg.sv]
`default_nettype none

package lsce_pkg;

    // Widths of the transaction fields.
    localparam int unsigned LSCE_SAMPLE_W    = 32;
    localparam int unsigned LSCE_VALUE_W     = 32;
    localparam int unsigned LSCE_INDEX_OUT_W = 32;

    // The index counter width. All of its bits are reported.
    localparam int unsigned LSCE_INDEX_WIDTH = 32;

    // Configuration port.
    localparam int unsigned LSCE_CFG_IDX_W  = 2;
    localparam int unsigned LSCE_CFG_DATA_W = 3;

    // Register indexes of the configuration port.
    typedef enum logic [LSCE_CFG_IDX_W-1:0] {
        CFG_BYTES_PER_SAMPLE   = 2'd0,
        CFG_PARALLEL_PORT_MODE = 2'd1,
        CFG_TWO_CHANNEL_MODE   = 2'd2
    } t_cfg_idx;

    // Word masks for the supported byte counts and for parallel-port mode.
    localparam logic [LSCE_SAMPLE_W-1:0] MASK_ONE_BYTE    = 32'h0000_00FF;
    localparam logic [LSCE_SAMPLE_W-1:0] MASK_TWO_BYTES   = 32'h0000_FFFF;
    localparam logic [LSCE_SAMPLE_W-1:0] MASK_PARALLEL    = 32'h0000_F8FF;
    localparam logic [LSCE_SAMPLE_W-1:0] MASK_THREE_BYTES = 32'h00FF_FFFF;

    // Lowest of the two bits kept in two-channel mode.
    localparam int unsigned TWO_CH_LSB = 14;

endpackage : lsce_pkg

`default_nettype wire

[hdl/lsce_if.sv]
`default_nettype none

// Input channel: one captured sample per transaction.
interface lsce_in_if
    import lsce_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [LSCE_SAMPLE_W-1:0] sample_bytes;
    logic                     is_last;

    modport source (output valid, output sample_bytes, output is_last, input ready);
    modport sink   (input valid, input sample_bytes, input is_last, output ready);
endinterface : lsce_in_if

// Output channel: one reported change per transaction.
interface lsce_out_if
    import lsce_pkg::*;
();
    logic                        valid;
    logic                        ready;
    logic [LSCE_VALUE_W-1:0]     reported_value;
    logic [LSCE_INDEX_OUT_W-1:0] sample_index;

    modport source (output valid, output reported_value, output sample_index, input ready);
    modport sink   (input valid, input reported_value, input sample_index, output ready);
endinterface : lsce_out_if

`default_nettype wire

[hdl/logic_sample_change_encoder.sv]
// Logic sample change encoder.
// Input channel i_in_ch carries one captured sample per transaction (raw bytes
// and a last-of-capture flag). Output channel o_out_ch carries a transaction
// with the assembled value and the sample's index whenever the word differs
// from the previous one, or the sample is the first or last of a capture.
// Samples that cause no change produce no output transaction.
// The configuration port (i_cfg_we, i_cfg_idx, i_cfg_data) sets the byte
// count and the two modes; write it only while the block is idle.
// The result is registered. Throughput is one sample per cycle while the skid
// register is empty: the compare and the index counter both sit in the
// single stage between the input port and the result register.
// A skid register behind the result register keeps i_in_ch.ready a pure
// register output; when the receiver stalls, one result waits in the result
// register, a second in the skid register, and then ready drops.
// Synchronous active-low reset clears the configuration to one byte per
// sample with both modes off, empties the output registers, clears the
// previous word and the index, and marks the next sample as first.
`default_nettype none

module logic_sample_change_encoder
    import lsce_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    lsce_in_if.sink                    i_in_ch,
    lsce_out_if.source                 o_out_ch,
    input  wire                        i_cfg_we,
    input  wire [LSCE_CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire [LSCE_CFG_DATA_W-1:0]  i_cfg_data
);

    // Configuration registers.
    logic [LSCE_CFG_DATA_W-1:0]  r_bytes_per_sample;
    logic                        r_parallel_mode;
    logic                        r_two_ch_mode;

    // Block state.
    logic [LSCE_SAMPLE_W-1:0]    r_prev_word;
    logic [LSCE_INDEX_WIDTH-1:0] r_index;
    logic                        r_first;

    // Result register and skid register.
    logic                        r_out_valid;
    logic [LSCE_VALUE_W-1:0]     r_out_value;
    logic [LSCE_INDEX_OUT_W-1:0] r_out_index;
    logic                        r_skd_valid;
    logic [LSCE_VALUE_W-1:0]     r_skd_value;
    logic [LSCE_INDEX_OUT_W-1:0] r_skd_index;

    logic                        in_accept;
    logic                        out_free;
    logic [LSCE_SAMPLE_W-1:0]    word;
    logic                        produce;
    logic [LSCE_VALUE_W-1:0]     rep_value;
    logic [LSCE_INDEX_OUT_W-1:0] rep_index;

    assign i_in_ch.ready = !r_skd_valid;
    assign in_accept     = i_in_ch.valid && !r_skd_valid;
    assign out_free      = !r_out_valid || o_out_ch.ready;

    assign o_out_ch.valid          = r_out_valid;
    assign o_out_ch.reported_value = r_out_value;
    assign o_out_ch.sample_index   = r_out_index;

    // Assemble the word from the configured number of bytes.
    always_comb begin
        case (r_bytes_per_sample)
            3'd0, 3'd1: begin
                word = i_in_ch.sample_bytes & MASK_ONE_BYTE;
            end
            3'd2: begin
                word = i_in_ch.sample_bytes & (r_parallel_mode ? MASK_PARALLEL : MASK_TWO_BYTES);
            end
            3'd3: begin
                word = i_in_ch.sample_bytes & MASK_THREE_BYTES;
            end
            default: begin
                word = i_in_ch.sample_bytes;
            end
        endcase
    end

    // Decide whether this sample is reported, and form the result.
    always_comb begin
        produce   = in_accept && (word != r_prev_word || i_in_ch.is_last || r_first);
        rep_value = r_two_ch_mode ? LSCE_VALUE_W'(word[TWO_CH_LSB +: 2]) : word;
        rep_index = LSCE_INDEX_OUT_W'(r_index);
    end

    // Configuration writes; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_per_sample <= LSCE_CFG_DATA_W'(1);
            r_parallel_mode    <= 1'b0;
            r_two_ch_mode      <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_BYTES_PER_SAMPLE:   r_bytes_per_sample <= i_cfg_data;
                CFG_PARALLEL_PORT_MODE: r_parallel_mode    <= i_cfg_data[0];
                CFG_TWO_CHANNEL_MODE:   r_two_ch_mode      <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // Previous word, index counter and first flag advance per sample.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_word <= '0;
            r_index     <= '0;
            r_first     <= 1'b1;
        end else if (in_accept) begin
            r_prev_word <= word;
            if (i_in_ch.is_last) begin
                r_index <= '0;
                r_first <= 1'b1;
            end else begin
                r_index <= r_index + LSCE_INDEX_WIDTH'(1);
                r_first <= 1'b0;
            end
        end
    end

    // Result and skid control. A new result is only made while the skid is empty.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_skd_valid <= 1'b0;
        end else if (out_free) begin
            if (r_skd_valid) begin
                r_out_valid <= 1'b1;
                r_skd_valid <= 1'b0;
            end else begin
                r_out_valid <= produce;
            end
        end else if (produce) begin
            r_skd_valid <= 1'b1;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (out_free) begin
            if (r_skd_valid) begin
                r_out_value <= r_skd_value;
                r_out_index <= r_skd_index;
            end else if (produce) begin
                r_out_value <= rep_value;
                r_out_index <= rep_index;
            end
        end else if (produce) begin
            r_skd_value <= rep_value;
            r_skd_index <= rep_index;
        end
    end

`ifndef SYNTHESIS
    // The skid register only fills behind a held result.
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skd_valid |-> r_out_valid)
        else $error("skid register holds a result while the result register is empty");

    // The first sample of a capture is always reported.
    a_first_reported: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_first) |=> r_out_valid)
        else $error("first sample of a capture was not reported");

    // A last sample restarts the capture.
    a_last_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_in_ch.is_last) |=> (r_index == '0 && r_first))
        else $error("index or first flag not restarted after the last sample");

    // Any other sample advances the index by one.
    a_index_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && !i_in_ch.is_last) |=>
            (r_index == $past(r_index) + LSCE_INDEX_WIDTH'(1) && !r_first))
        else $error("index did not advance by one");

    // A waiting skid entry must stay while the output is stalled; no new samples are taken then.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skd_valid && !o_out_ch.ready) |=> r_skd_valid)
        else $error("skid entry lost while the receiver stalls");
`endif

endmodule : logic_sample_change_encoder

`default_nettype wire
